// ===== src/bwt_block_sort_transform_assert.svh =====
// assertion macros for the bwt block sort transform
`ifndef BWT_BLOCK_SORT_TRANSFORM_ASSERT_SVH
`define BWT_BLOCK_SORT_TRANSFORM_ASSERT_SVH
`define BWT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/bwt_pkg.sv =====
// shared types and constants for the bwt block sort transform
package bwt_pkg;
  localparam int unsigned BlockDepth = 1024;
  localparam int unsigned IdxW = 11;
  localparam int unsigned AddrW = 10;
  localparam logic [7:0] MarkerByte = 8'h3F;
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [7:0]      data_byte;
    logic            end_of_block;
    logic [IdxW-1:0] read_position;
  } bwt_in_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            is_marker;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] last_index;
    logic [IdxW-1:0] block_count;
    logic            status;
  } bwt_out_t;

  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdRead, CmdInit, CmdRun, CmdStep, CmdCmp, CmdRdByte, CmdEmit
  } bwt_cmd_e;

  typedef struct packed {
    logic block_full;
    logic init_done;
    logic both;
    logic run_end;
    logic pass_end;
    logic sort_end;
    logic cmp_done;
  } bwt_stat_t;
endpackage

// ===== src/bwt_block_sort_transform.sv =====
// bwt block sort transform top level
// load: one transaction per cycle; the block-ending load keeps busy high for the sort
// sort: init of n+1 order entries, then ceil(log2(n+1)) passes; a run takes StRun,
//   an entry StFetch, StStep; a byte compared while both runs hold entries StWait, StCmp
// read: StRdByte, StRdWait, then StEmit registers result and strobe; never stalled
// rst_ni clears fill count, ready flag and indices; store and order memories keep no reset
module bwt_block_sort_transform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bwt_pkg::bwt_in_t  item_i,
  output logic              strobe,
  output bwt_pkg::bwt_out_t result_o
);
  import bwt_pkg::*;

  bwt_cmd_e  cmd;
  bwt_stat_t stat;

  bwt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .operation_i(item_i.operation),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy), .strobe_o(strobe)
  );

  bwt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(item_i),
    .stat_o(stat), .result_o(result_o)
  );
endmodule

// ===== src/bwt_datapath.sv =====
// storage, merge sort datapath and result formatting
module bwt_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bwt_pkg::bwt_cmd_e  cmd_i,
  input  bwt_pkg::bwt_in_t   item_i,
  output bwt_pkg::bwt_stat_t stat_o,
  output bwt_pkg::bwt_out_t  result_o
);
  import bwt_pkg::*;

  logic [7:0]       store_q [BlockDepth];
  logic [IdxW-1:0]  ord0_q [BlockDepth+1];
  logic [IdxW-1:0]  ord1_q [BlockDepth+1];
  logic [IdxW-1:0]  fill_q, fill_n, first_q, last_q;
  logic             ready_q, bank_q;
  logic [IdxW-1:0]  width_q, lo_q, mid_q, hi_q, p_q, q_q, o_q;
  logic [IdxW-1:0]  sa_q, sb_q, ka_q, kb_q, pos_q;
  logic [IdxW-1:0]  rda_q, rdb_q, rd_addr;
  logic [7:0]       xa_q, xb_q;
  logic [AddrW-1:0] byte_addr;
  logic [IdxW-1:0]  total, mid_c, hi_c;
  logic [IdxW+1:0]  lo_w, width2_w, total_w, mid_w, hi_w;
  logic             p_more, q_more, cmp_hit, take_a, take_b, wr_en, wr_bank;
  logic [IdxW-1:0]  wr_data;
  bwt_out_t         res_d, res_q;

  assign total    = fill_q + IdxW'(1);
  assign fill_n   = ready_q ? IdxW'(1) : fill_q + IdxW'(1);
  assign byte_addr = ready_q ? '0 : fill_q[AddrW-1:0];
  assign lo_w     = {2'b00, lo_q};
  assign width2_w = {1'b0, width_q, 1'b0};
  assign total_w  = {2'b00, total};
  assign mid_w    = lo_w + {2'b00, width_q};
  assign hi_w     = lo_w + width2_w;
  assign mid_c    = (mid_w < total_w) ? mid_w[IdxW-1:0] : total;
  assign hi_c     = (hi_w < total_w) ? hi_w[IdxW-1:0] : total;
  assign p_more   = (p_q < mid_q);
  assign q_more   = (q_q < hi_q);
  assign cmp_hit  = (kb_q == fill_q) || (ka_q == fill_q) || (xa_q != xb_q);
  assign rd_addr  = (cmd_i == CmdRead) ? item_i.read_position : p_q;

  // pick which entry goes to the merge output this cycle
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    case (cmd_i)
      CmdStep: begin
        take_a = p_more && !q_more;
        take_b = !p_more && q_more;
      end
      CmdCmp: begin
        // an exhausted suffix is the shorter one and sorts later
        if (kb_q == fill_q) begin
          take_a = 1'b1;
        end else if (ka_q == fill_q) begin
          take_b = 1'b1;
        end else if (xa_q != xb_q) begin
          take_a = (xa_q < xb_q);
          take_b = (xb_q < xa_q);
        end
      end
      default: ;
    endcase
    wr_en   = take_a || take_b || (cmd_i == CmdInit);
    wr_bank = (cmd_i == CmdInit) ? bank_q : !bank_q;
    if (cmd_i == CmdInit) begin
      wr_data = o_q;
    end else if (cmd_i == CmdStep) begin
      wr_data = take_a ? rda_q : rdb_q;
    end else begin
      wr_data = take_a ? sa_q : sb_q;
    end
  end

  always_comb begin
    res_d = '0;
    res_d.status = 1'b1;
    if (ready_q) begin
      res_d.first_index = first_q;
      res_d.last_index = last_q;
      res_d.block_count = fill_q;
      if (pos_q <= fill_q) begin
        res_d.status = 1'b0;
        if (sa_q == '0) begin
          res_d.out_byte = MarkerByte;
          res_d.is_marker = 1'b1;
        end else begin
          res_d.out_byte = xa_q;
        end
      end
    end
  end

  // store and the two order banks; merges read the source bank, write the other; init writes the source
  always_ff @(posedge clk_i) begin
    if (cmd_i == CmdLoad) store_q[byte_addr] <= item_i.data_byte;
    xa_q <= store_q[ka_q[AddrW-1:0]];
    xb_q <= store_q[kb_q[AddrW-1:0]];
    if (wr_en && !wr_bank) ord0_q[o_q] <= wr_data;
    if (wr_en && wr_bank) ord1_q[o_q] <= wr_data;
    if (bank_q) begin
      rda_q <= ord1_q[rd_addr];
      rdb_q <= ord1_q[q_q];
    end else begin
      rda_q <= ord0_q[rd_addr];
      rdb_q <= ord0_q[q_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; ready_q <= 1'b0; first_q <= '0; last_q <= '0; bank_q <= 1'b0;
      width_q <= '0; lo_q <= '0; mid_q <= '0; hi_q <= '0; p_q <= '0;
      q_q <= '0; o_q <= '0; sa_q <= '0; sb_q <= '0; ka_q <= '0; kb_q <= '0;
      pos_q <= '0; res_q <= '0;
    end else begin
      case (cmd_i)
        CmdLoad: begin
          ready_q <= 1'b0;
          fill_q <= fill_n;
          o_q <= '0;
          lo_q <= '0;
          width_q <= IdxW'(1);
        end
        CmdInit: o_q <= o_q + IdxW'(1);
        CmdRun: begin
          mid_q <= mid_c;
          hi_q <= hi_c;
          p_q <= lo_q;
          q_q <= mid_c;
          o_q <= lo_q;
        end
        CmdStep: begin
          if (p_more && q_more) begin
            sa_q <= rda_q; sb_q <= rdb_q; ka_q <= rda_q; kb_q <= rdb_q;
          end else if (take_a) begin
            p_q <= p_q + IdxW'(1); o_q <= o_q + IdxW'(1);
          end else if (take_b) begin
            q_q <= q_q + IdxW'(1); o_q <= o_q + IdxW'(1);
          end else if (hi_w >= total_w) begin
            // pass complete: swap banks and double the run width
            bank_q <= !bank_q;
            lo_q <= '0;
            width_q <= {width_q[IdxW-2:0], 1'b0};
            if (width2_w >= total_w) ready_q <= 1'b1;
          end else begin
            lo_q <= hi_w[IdxW-1:0];
          end
        end
        CmdCmp: begin
          if (take_a) begin
            p_q <= p_q + IdxW'(1); o_q <= o_q + IdxW'(1);
          end else if (take_b) begin
            q_q <= q_q + IdxW'(1); o_q <= o_q + IdxW'(1);
          end else begin
            ka_q <= ka_q + IdxW'(1); kb_q <= kb_q + IdxW'(1);
          end
        end
        CmdRead: pos_q <= item_i.read_position;
        CmdRdByte: begin
          sa_q <= rda_q;
          ka_q <= rda_q - IdxW'(1);
        end
        CmdEmit: res_q <= res_d;
        default: ;
      endcase
      // every pass writes each suffix once, so the last pass leaves the indices
      if (take_a || take_b) begin
        if (wr_data == IdxW'(1)) first_q <= o_q;
        if (wr_data == '0) last_q <= o_q;
      end
    end
  end

  assign stat_o.block_full = item_i.end_of_block || (fill_n == IdxW'(BlockDepth));
  assign stat_o.init_done  = (o_q == fill_q);
  assign stat_o.both       = p_more && q_more;
  assign stat_o.run_end    = !p_more && !q_more;
  assign stat_o.pass_end   = (hi_w >= total_w);
  assign stat_o.sort_end   = (width2_w >= total_w);
  assign stat_o.cmp_done   = cmp_hit;
  assign result_o = res_q;
endmodule

// ===== src/bwt_ctrl.sv =====
// controller sequencing loads, the merge sort passes and reads
module bwt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               operation_i,
  input  bwt_pkg::bwt_stat_t stat_i,
  output bwt_pkg::bwt_cmd_e  cmd_o,
  output logic               busy_o,
  output logic               strobe_o
);
  import bwt_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StInit, StRun, StFetch, StStep, StWait, StCmp, StRdByte, StRdWait, StEmit
  } state_e;

  state_e state_q;
  logic   strobe_q;
  logic   accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    case (state_q)
      StIdle:   cmd_o = accept ? (operation_i == OpLoad ? CmdLoad : CmdRead) : CmdNone;
      StInit:   cmd_o = CmdInit;
      StRun:    cmd_o = CmdRun;
      StFetch:  cmd_o = CmdNone;
      StStep:   cmd_o = CmdStep;
      StWait:   cmd_o = CmdNone;
      StCmp:    cmd_o = CmdCmp;
      StRdByte: cmd_o = CmdRdByte;
      StRdWait: cmd_o = CmdNone;
      StEmit:   cmd_o = CmdEmit;
      default:  cmd_o = CmdNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (state_q == StEmit);
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (operation_i == OpLoad) begin
              if (stat_i.block_full) state_q <= StInit;
            end else begin
              state_q <= StRdByte;
            end
          end
        end
        StInit:   if (stat_i.init_done) state_q <= StRun;
        StRun:    state_q <= StFetch;
        StFetch:  state_q <= StStep;
        StStep: begin
          if (stat_i.both) begin
            state_q <= StWait;
          end else if (stat_i.run_end) begin
            state_q <= (stat_i.pass_end && stat_i.sort_end) ? StIdle : StRun;
          end else begin
            state_q <= StFetch;
          end
        end
        StWait:   state_q <= StCmp;
        StCmp:    state_q <= stat_i.cmp_done ? StFetch : StWait;
        StRdByte: state_q <= StRdWait;
        StRdWait: state_q <= StEmit;
        StEmit:   state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign strobe_o = strobe_q;
endmodule

// ===== src/bwt_checker.sv =====
// port level checker for the bwt block sort transform
`include "bwt_block_sort_transform_assert.svh"
module bwt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input bwt_pkg::bwt_in_t item_i,
  input logic             strobe
);
  import bwt_pkg::*;

  `BWT_ASSERT_IMPL(strobe_busy_a, clk_i, rst_ni, strobe, !busy)
  `BWT_ASSERT_NEXT(strobe_single_a, clk_i, rst_ni, strobe, !strobe)
  `BWT_ASSERT_NEXT(read_busy_a, clk_i, rst_ni, start && !busy && item_i.operation == OpRead, busy)
  `BWT_ASSERT_NEXT(read_result_a, clk_i, rst_ni, start && !busy && item_i.operation == OpRead, ##3 strobe)
endmodule

bind bwt_block_sort_transform bwt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
  .strobe(strobe)
);
